// ----- rtl/vgrt_pkg.sv -----
// Shared types and constants for the voxel grid ray traversal block.
package vgrt_pkg;

  localparam int VGRT_FRAC_BITS  = 16;
  localparam int VGRT_COORD_BITS = 32;
  localparam int DIR_FRAC        = 14;
  localparam int POS_W           = 48;
  localparam int DIR_W           = 16;
  localparam int MAG_W           = 16;
  localparam int DIST_W          = 32;
  localparam int CELL_W          = 32;
  localparam int FACE_W          = 2;
  localparam int IN_DATA_W       = 192;
  localparam int OUT_DATA_W      = 136;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [FACE_W-1:0] FACE_POS  = 2'b01;
  localparam logic [FACE_W-1:0] FACE_NEG  = 2'b11;
  localparam logic [FACE_W-1:0] FACE_NONE = 2'b00;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_STORE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/vgrt_div.sv -----
// Radix-2 restoring divider: quotient of 2^(DIR_FRAC+FRAC_BITS) by a direction magnitude.
module vgrt_div
  import vgrt_pkg::*;
#(
  parameter int FRAC_BITS = VGRT_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [MAG_W-1:0]                   divisor,
  output div_stat_t                          stat,
  output logic [DIR_FRAC+FRAC_BITS:0]        quotient
);

  localparam int QW = DIR_FRAC + FRAC_BITS + 1;
  localparam int CW = $clog2(QW);

  logic [MAG_W-1:0] div_r, div_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             dbit;
  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;

  always_comb begin
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    // the dividend is a single one at its top bit
    dbit     = (cnt_r == CW'(QW - 1));
    trial    = {rem_r, dbit};
    diff     = trial - {1'b0, div_r};
    if (start) begin
      div_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = CW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[MAG_W-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[MAG_W-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ----- rtl/vgrt_mul.sv -----
// Registered multiplier for the first boundary distance, with shift and saturation.
module vgrt_mul
  import vgrt_pkg::*;
#(
  parameter int FRAC_BITS = VGRT_FRAC_BITS
) (
  input  logic               clk,
  input  logic [DIST_W-1:0]  unit,
  input  logic [FRAC_BITS:0] mult,
  output logic [DIST_W-1:0]  bound
);

  localparam int PW = DIST_W + FRAC_BITS + 1;

  logic [PW-1:0]   prod_r, prod_nxt;
  logic [DIST_W:0] shifted;

  assign prod_nxt = PW'(unit) * PW'(mult);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign shifted = prod_r[PW-1:FRAC_BITS];
  assign bound   = shifted[DIST_W] ? DIST_MAX : shifted[DIST_W-1:0];

endmodule

// ----- rtl/voxel_grid_ray_traversal.sv -----
// Top level of the voxel grid ray traversal block: ray setup sequencer and step unit.
//
// Usage:
//   Input stream (in_tvalid/in_tready/in_tdata/in_tuser) carries requests.
//   in_tuser = 0 loads a new ray from position and direction; no result follows.
//   in_tuser = 1 steps the ray one voxel; one result follows on the output stream.
//   A start request holds in_tready low while the ray setup runs: the single radix-2
//   divider, shared over the three axes, forms 1/|dir| one quotient bit per cycle
//   after a load step and before a done step, and each division is followed by a
//   multiply state and a store state.
//   A step request compares the three boundary distances, adds the unit distance on
//   the winner and latches the result into the output register; the result is
//   offered the cycle after acceptance.
//   in_tready is high while no ray setup runs and the output register is empty or
//   being drained in the same cycle, so a stalled receiver holds off new requests
//   while the pending result holds steady.
//   Reset (rst_n low, synchronous) puts the ray at cell zero with every distance
//   saturated, so a step before any start moves along y; the output is emptied.
//   Distances saturate at all ones; cell indices wrap at COORD_BITS bits.
module voxel_grid_ray_traversal
  import vgrt_pkg::*;
#(
  parameter int FRAC_BITS  = VGRT_FRAC_BITS,
  parameter int COORD_BITS = VGRT_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x[47:0], pos_y[95:48], pos_z[143:96], dir_x[159:144], dir_y[175:160], dir_z[191:176]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cell_x[31:0], cell_y[63:32], cell_z[95:64], face_x[97:96], face_y[99:98],
  // face_z[101:100], hit_distance[133:102], zero[135:134]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int QW = DIR_FRAC + FRAC_BITS + 1;

  // ray state
  logic [COORD_BITS-1:0] cell_r [3];
  logic [COORD_BITS-1:0] cell_nxt [3];
  logic [DIST_W-1:0]     bnd_r [3];
  logic [DIST_W-1:0]     bnd_nxt [3];
  logic [DIST_W-1:0]     unit_r [3];
  logic [DIST_W-1:0]     unit_nxt [3];
  logic                  neg_r [3];
  logic                  neg_nxt [3];

  // latched start request
  logic [POS_W-1:0] pos_r [3];
  logic [DIR_W-1:0] dir_r [3];

  state_t              state_r, state_nxt;
  axis_t               axis_r, axis_nxt;
  logic [DIST_W-1:0]   utmp_r, utmp_nxt;
  logic [FRAC_BITS:0]  mult_r, mult_nxt;
  logic                mzero_r, mzero_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]     ocell_r [3];
  logic [CELL_W-1:0]     ocell_nxt [3];
  logic [FACE_W-1:0]     oface_r [3];
  logic [FACE_W-1:0]     oface_nxt [3];
  logic [DIST_W-1:0]     ohit_r, ohit_nxt;

  logic in_acc;
  logic start_acc;
  logic step_acc;

  // setup datapath
  logic [POS_W-1:0]      cur_pos;
  logic [DIR_W-1:0]      cur_dir;
  logic                  cur_neg;
  logic [MAG_W-1:0]      cur_mag;
  logic signed [63:0]    pos_ext;
  logic signed [63:0]    whole;
  logic [FRAC_BITS-1:0]  cur_frac;
  logic [FRAC_BITS:0]    cur_mult;
  logic [QW-1:0]         quo;
  logic [63:0]           quo_ext;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [DIST_W-1:0]     mul_bound;

  // step datapath
  axis_t                 sel;
  logic [DIST_W-1:0]     hit;
  logic [DIST_W:0]       sum;
  logic [COORD_BITS-1:0] cstep;

  function automatic logic [CELL_W-1:0] cell32(input logic [COORD_BITS-1:0] c);
    logic [63:0] ext;
    ext = {{(64 - COORD_BITS){c[COORD_BITS-1]}}, c};
    return ext[CELL_W-1:0];
  endfunction

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign start_acc = in_acc && (in_tuser == REQ_START);
  assign step_acc  = in_acc && (in_tuser == REQ_STEP);

  // per-axis setup operands
  assign cur_pos  = pos_r[axis_r];
  assign cur_dir  = dir_r[axis_r];
  assign cur_neg  = cur_dir[DIR_W-1];
  assign cur_mag  = cur_neg ? MAG_W'(-cur_dir) : cur_dir;
  assign pos_ext  = {{(64 - POS_W){cur_pos[POS_W-1]}}, cur_pos};
  assign whole    = pos_ext >>> FRAC_BITS;
  assign cur_frac = cur_pos[FRAC_BITS-1:0];
  assign cur_mult = cur_neg ? {1'b0, cur_frac}
                            : (FRAC_BITS + 1)'((1 << FRAC_BITS) - int'(cur_frac));
  assign quo_ext  = 64'(quo);
  assign div_start = (state_r == S_DIV_GO);

  vgrt_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (cur_mag),
    .stat    (div_stat),
    .quotient(quo)
  );

  vgrt_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .unit (utmp_r),
    .mult (mult_r),
    .bound(mul_bound)
  );

  // axis choice: ties go to y, a z/x tie goes to z
  always_comb begin
    if (bnd_r[0] < bnd_r[2]) begin
      sel = (bnd_r[0] < bnd_r[1]) ? AX_X : AX_Y;
    end else begin
      sel = (bnd_r[2] < bnd_r[1]) ? AX_Z : AX_Y;
    end
  end

  assign hit   = bnd_r[sel];
  assign sum   = {1'b0, hit} + {1'b0, unit_r[sel]};
  assign cstep = cell_r[sel] + (neg_r[sel] ? {COORD_BITS{1'b1}} : COORD_BITS'(1));

  // sequencer and state update
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    utmp_nxt  = utmp_r;
    mult_nxt  = mult_r;
    mzero_nxt = mzero_r;
    for (int a = 0; a < 3; a++) begin
      cell_nxt[a] = cell_r[a];
      bnd_nxt[a]  = bnd_r[a];
      unit_nxt[a] = unit_r[a];
      neg_nxt[a]  = neg_r[a];
    end
    unique case (state_r)
      S_IDLE: begin
        if (start_acc) begin
          axis_nxt  = AX_X;
          state_nxt = S_DIV_GO;
        end else if (step_acc) begin
          bnd_nxt[sel]  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
          cell_nxt[sel] = cstep;
        end
      end
      S_DIV_GO: begin
        cell_nxt[axis_r] = whole[COORD_BITS-1:0];
        neg_nxt[axis_r]  = cur_neg;
        mult_nxt         = cur_mult;
        mzero_nxt        = (cur_mag == '0);
        state_nxt        = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          // saturate the reciprocal; a zero direction gets the saturated unit distance
          if (mzero_r || (quo_ext > 64'(DIST_MAX))) begin
            utmp_nxt = DIST_MAX;
          end else begin
            utmp_nxt = quo_ext[DIST_W-1:0];
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        unit_nxt[axis_r] = utmp_r;
        state_nxt        = S_STORE;
      end
      S_STORE: begin
        bnd_nxt[axis_r] = (utmp_r == DIST_MAX) ? DIST_MAX : mul_bound;
        if (axis_r == AX_Z) begin
          state_nxt = S_IDLE;
        end else begin
          axis_nxt  = axis_t'(axis_r + 2'd1);
          state_nxt = S_DIV_GO;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    ohit_nxt      = ohit_r;
    for (int a = 0; a < 3; a++) begin
      ocell_nxt[a] = ocell_r[a];
      oface_nxt[a] = oface_r[a];
    end
    if (step_acc) begin
      out_valid_nxt = 1'b1;
      ohit_nxt      = hit;
      for (int a = 0; a < 3; a++) begin
        ocell_nxt[a] = (axis_t'(a) == sel) ? cell32(cstep) : cell32(cell_r[a]);
        oface_nxt[a] = FACE_NONE;
      end
      oface_nxt[sel] = neg_r[sel] ? FACE_POS : FACE_NEG;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AX_X;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        cell_r[a] <= '0;
        bnd_r[a]  <= DIST_MAX;
        unit_r[a] <= DIST_MAX;
        neg_r[a]  <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      for (int a = 0; a < 3; a++) begin
        cell_r[a] <= cell_nxt[a];
        bnd_r[a]  <= bnd_nxt[a];
        unit_r[a] <= unit_nxt[a];
        neg_r[a]  <= neg_nxt[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    utmp_r  <= utmp_nxt;
    mult_r  <= mult_nxt;
    mzero_r <= mzero_nxt;
    ohit_r  <= ohit_nxt;
    for (int a = 0; a < 3; a++) begin
      ocell_r[a] <= ocell_nxt[a];
      oface_r[a] <= oface_nxt[a];
    end
    if (start_acc) begin
      for (int a = 0; a < 3; a++) begin
        pos_r[a] <= in_tdata[a*POS_W +: POS_W];
        dir_r[a] <= in_tdata[3*POS_W + a*DIR_W +: DIR_W];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, ohit_r, oface_r[2], oface_r[1], oface_r[0],
                       ocell_r[2], ocell_r[1], ocell_r[0]};

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the voxel grid ray traversal block: directed ray table, then random rays.
module testbench
  import vgrt_pkg::*;
();

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_PCT     = 16;
  localparam int MAX_REPORTS  = 10;
  // One ray setup: a shared serial divider runs once per axis.
  localparam int SETUP_CYCLES = 3 * (DIR_FRAC + VGRT_FRAC_BITS + 5);
  localparam int SETTLE       = SETUP_CYCLES + 16;
  localparam int CYCLE_LIMIT  = 400000;

  // One request as it travels on the input stream.
  typedef struct packed {
    logic             is_step;
    logic [2:0][47:0] pos;
    logic [2:0][15:0] dir;
  } ray_req_t;

  // One step result: cell entered, crossed face and entry distance.
  typedef struct packed {
    logic [2:0][31:0] cells;
    logic [2:0][1:0]  face;
    logic [31:0]      hit;
  } voxel_hit_t;

  // Directed table row; typed rows carry a hand-written result.
  typedef struct packed {
    ray_req_t   req;
    logic       typed;
    voxel_hit_t want;
  } ray_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Ray state as the block should hold it.
  logic [CELL_W-1:0] trace_cell  [3];
  logic [DIST_W-1:0] trace_bound [3];
  logic [DIST_W-1:0] trace_unit  [3];
  logic              trace_neg   [3];

  ray_row_t    ray_script[$];
  voxel_hit_t  pending_hits[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          steady_flow;

  voxel_grid_ray_traversal uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Put the ray back where reset leaves it: cell zero, every distance saturated.
  function automatic void reset_ray();
    for (int a = 0; a < 3; a++) begin
      trace_cell[a]  = '0;
      trace_bound[a] = DIST_MAX;
      trace_unit[a]  = DIST_MAX;
      trace_neg[a]   = 1'b0;
    end
  endfunction

  // Load a new ray: start cell, step sign, 1/|dir| and the first face distance.
  function automatic void load_ray(input ray_req_t r);
    logic [47:0] p;
    logic [15:0] d;
    logic [16:0] mag;
    logic [63:0] u, m, b;
    for (int a = 0; a < 3; a++) begin
      p = r.pos[a];
      d = r.dir[a];
      trace_cell[a] = p[VGRT_FRAC_BITS +: CELL_W];
      mag = d[DIR_W-1] ? 17'h10000 - {1'b0, d} : {1'b0, d};
      // A zero component never reaches a face: park its distance at the top.
      u = (mag == '0) ? 64'(DIST_MAX) : (64'd1 << (DIR_FRAC + VGRT_FRAC_BITS)) / 64'(mag);
      if (u > 64'(DIST_MAX)) u = 64'(DIST_MAX);
      if (u == 64'(DIST_MAX)) begin
        b = u;
      end else begin
        // Negative step measures back to the cell floor, positive step up to the next face.
        m = d[DIR_W-1] ? 64'(p[VGRT_FRAC_BITS-1:0])
                       : (64'd1 << VGRT_FRAC_BITS) - 64'(p[VGRT_FRAC_BITS-1:0]);
        b = (u * m) >> VGRT_FRAC_BITS;
        if (b > 64'(DIST_MAX)) b = 64'(DIST_MAX);
      end
      trace_unit[a]  = u[DIST_W-1:0];
      trace_bound[a] = b[DIST_W-1:0];
      trace_neg[a]   = d[DIR_W-1];
    end
  endfunction

  // Take one step along the nearest face and return what the block must report.
  function automatic voxel_hit_t advance_ray();
    axis_t       ax;
    int          i;
    logic [32:0] sum;
    voxel_hit_t  h;
    // Ties go to y; a z/x tie goes to z.
    if (trace_bound[0] < trace_bound[2])
      ax = (trace_bound[0] < trace_bound[1]) ? AX_X : AX_Y;
    else
      ax = (trace_bound[2] < trace_bound[1]) ? AX_Z : AX_Y;
    i = int'(ax);
    h = '0;
    h.hit = trace_bound[i];
    sum = {1'b0, trace_bound[i]} + {1'b0, trace_unit[i]};
    trace_bound[i] = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    trace_cell[i]  = trace_neg[i] ? trace_cell[i] - 1'b1 : trace_cell[i] + 1'b1;
    for (int a = 0; a < 3; a++)
      h.cells[a] = trace_cell[a];
    // Normal points against the step.
    h.face[i] = trace_neg[i] ? FACE_POS : FACE_NEG;
    return h;
  endfunction

  function automatic void row_start(input logic [47:0] px, py, pz, input logic [15:0] dx, dy, dz);
    ray_row_t s;
    s = '0;
    s.req.is_step = REQ_START;
    s.req.pos = {pz, py, px};
    s.req.dir = {dz, dy, dx};
    ray_script.push_back(s);
  endfunction

  // Step row; with typed clear the predictor supplies the result.
  function automatic void row_step(input logic typed, input logic [31:0] cx, cy, cz,
                                   input logic [1:0] fx, fy, fz, input logic [31:0] hit);
    ray_row_t s;
    s = '0;
    s.req.is_step = REQ_STEP;
    s.typed = typed;
    s.want.cells = {cz, cy, cx};
    s.want.face = {fz, fy, fx};
    s.want.hit = hit;
    ray_script.push_back(s);
  endfunction

  // Offer one request, hold it until taken, then advance the predicted ray.
  task automatic send_request(input ray_req_t r, input logic typed, input voxel_hit_t want);
    voxel_hit_t h;
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.is_step;
    in_tdata  <= {r.dir, r.pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (r.is_step == REQ_STEP) begin
      h = advance_ray();
      pending_hits.push_back(typed ? want : h);
    end else begin
      load_ray(r);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Receiver: stall at random except in the steady stretch.
  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare every taken result with the oldest pending one.
  always @(posedge clk) begin
    voxel_hit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h with nothing pending", out_tdata);
      end else begin
        want = pending_hits.pop_front();
        check_field("cell_x", want.cells[0], out_tdata[31:0]);
        check_field("cell_y", want.cells[1], out_tdata[63:32]);
        check_field("cell_z", want.cells[2], out_tdata[95:64]);
        check_field("face_x", 32'(want.face[0]), 32'(out_tdata[97:96]));
        check_field("face_y", 32'(want.face[1]), 32'(out_tdata[99:98]));
        check_field("face_z", 32'(want.face[2]), 32'(out_tdata[101:100]));
        check_field("hit_distance", want.hit, out_tdata[133:102]);
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("voxel_grid_ray_traversal test failed");
      $finish;
    end
  end

  initial begin
    ray_req_t   r;
    voxel_hit_t none;
    int         issued;
    int         steps;
    int         kind;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= REQ_START;
    out_tready  <= 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    steady_flow = 1'b0;
    none        = '0;
    reset_ray();

    // Steps straight out of reset: all distances saturated, so y wins.
    row_step(1, 32'd0, 32'd1, 32'd0, FACE_NONE, FACE_NEG, FACE_NONE, DIST_MAX);
    row_step(1, 32'd0, 32'd2, 32'd0, FACE_NONE, FACE_NEG, FACE_NONE, DIST_MAX);
    // Unit x direction from the origin: one cell per 1.0 of distance.
    row_start(48'd0, 48'd0, 48'd0, 16'h4000, 16'h0000, 16'h0000);
    row_step(1, 32'd1, 32'd0, 32'd0, FACE_NEG, FACE_NONE, FACE_NONE, 32'h0001_0000);
    row_step(1, 32'd2, 32'd0, 32'd0, FACE_NEG, FACE_NONE, FACE_NONE, 32'h0002_0000);
    // Position and direction extremes.
    row_start(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
              16'h8000, 16'h7FFF, 16'hFFFF);
    row_step(0, '0, '0, '0, '0, '0, '0, '0);
    row_step(0, '0, '0, '0, '0, '0, '0, '0);
    row_step(0, '0, '0, '0, '0, '0, '0, '0);
    row_start(48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
              16'h7FFF, 16'h8000, 16'h0001);
    row_step(0, '0, '0, '0, '0, '0, '0, '0);
    row_step(0, '0, '0, '0, '0, '0, '0, '0);
    row_step(0, '0, '0, '0, '0, '0, '0, '0);
    // Zero direction: everything saturated again, steps fall to y.
    row_start(48'h0000_0003_4000, 48'h0000_0003_4000, 48'h0000_0003_4000,
              16'h0000, 16'h0000, 16'h0000);
    row_step(1, 32'd3, 32'd4, 32'd3, FACE_NONE, FACE_NEG, FACE_NONE, DIST_MAX);
    row_step(1, 32'd3, 32'd5, 32'd3, FACE_NONE, FACE_NEG, FACE_NONE, DIST_MAX);
    // -1.5 on every axis, negative unit direction: three-way tie, then z over x, then x.
    row_start(48'hFFFF_FFFE_8000, 48'hFFFF_FFFE_8000, 48'hFFFF_FFFE_8000,
              16'hC000, 16'hC000, 16'hC000);
    row_step(1, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFE,
             FACE_NONE, FACE_POS, FACE_NONE, 32'h0000_8000);
    row_step(1, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFD,
             FACE_NONE, FACE_NONE, FACE_POS, 32'h0000_8000);
    row_step(1, 32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFD,
             FACE_POS, FACE_NONE, FACE_NONE, 32'h0000_8000);
    // Cell index wraps upward past the largest positive cell.
    row_start(48'h7FFF_FFFF_0000, 48'd0, 48'd0, 16'h4000, 16'h0000, 16'h0000);
    row_step(1, 32'h8000_0000, 32'd0, 32'd0, FACE_NEG, FACE_NONE, FACE_NONE, 32'h0001_0000);
    // Cell index wraps downward; on a face with a negative step the entry distance is zero.
    row_start(48'h8000_0000_0000, 48'd0, 48'd0, 16'hC000, 16'h0000, 16'h0000);
    row_step(1, 32'h7FFF_FFFF, 32'd0, 32'd0, FACE_POS, FACE_NONE, FACE_NONE, 32'h0000_0000);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (ray_script[i])
      send_request(ray_script[i].req, ray_script[i].typed, ray_script[i].want);

    // Random rays: mostly a start followed by a run of steps, with stray steps and
    // back-to-back starts mixed in.
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      steady_flow = (issued >= 500 && issued < 800);
      r = '0;
      r.is_step = REQ_START;
      for (int a = 0; a < 3; a++) begin
        kind = $urandom_range(0, 7);
        case (kind)
          0: r.pos[a] = {($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000), 16'($urandom)};
          1: r.pos[a] = {32'($urandom), 16'h0000};
          2: r.pos[a] = {32'($urandom_range(0, 40)) - 32'd20, 16'($urandom)};
          default: r.pos[a] = {16'($urandom), 32'($urandom)};
        endcase
        kind = $urandom_range(0, 7);
        case (kind)
          // Tiny direction: huge unit distance, saturates after a few steps.
          0: begin
            r.dir[a] = 16'($urandom_range(1, 3));
            if ($urandom_range(0, 1)) r.dir[a] = -r.dir[a];
          end
          1: r.dir[a] = 16'h0000;
          2: r.dir[a] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          default: r.dir[a] = 16'($urandom);
        endcase
      end
      if ($urandom_range(0, 99) >= 5) begin
        send_request(r, 1'b0, none);
        issued++;
      end
      steps = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 40);
      repeat (steps) begin
        r.is_step = REQ_STEP;
        r.pos = {16'($urandom), 32'($urandom), 16'($urandom), 32'($urandom),
                 16'($urandom), 32'($urandom)};
        r.dir = {16'($urandom), 16'($urandom), 16'($urandom)};
        send_request(r, 1'b0, none);
        issued++;
      end
    end
    steady_flow = 1'b0;
    in_tvalid <= 1'b0;

    // Drain results, then allow a trailing ray setup to finish.
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0)
      $display("voxel_grid_ray_traversal test passed");
    else
      $display("voxel_grid_ray_traversal test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vgrt_pkg.sv
rtl/vgrt_div.sv
rtl/vgrt_mul.sv
rtl/voxel_grid_ray_traversal.sv
sim/testbench.sv
